>>> rtl/core/half_shell_neighbor_cell_ids_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef HALF_SHELL_NEIGHBOR_CELL_IDS_ASSERT_SVH
`define HALF_SHELL_NEIGHBOR_CELL_IDS_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define HSN_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that holds through reset as well.
`define HSN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/hsn_pkg.sv
package hsn_pkg;

  localparam int NUM_SLOTS = 13;
  localparam int SLOT_W    = 4;
  localparam int COORD_W   = 6;
  localparam int CNT_W     = 7;
  localparam int ID_W      = 18;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_COUNT_X = 2'd0;
  localparam logic [1:0] REG_COUNT_Y = 2'd1;
  localparam logic [1:0] REG_COUNT_Z = 2'd2;

  typedef enum logic [1:0] {
    OFF_M = 2'd0,
    OFF_Z = 2'd1,
    OFF_P = 2'd2
  } off_t;

  typedef struct packed {
    off_t dx;
    off_t dy;
    off_t dz;
  } stencil_t;

  localparam stencil_t STENCIL [NUM_SLOTS] = '{
    '{OFF_P, OFF_Z, OFF_Z}, '{OFF_Z, OFF_P, OFF_Z}, '{OFF_P, OFF_P, OFF_Z},
    '{OFF_P, OFF_M, OFF_Z}, '{OFF_P, OFF_Z, OFF_M}, '{OFF_Z, OFF_P, OFF_M},
    '{OFF_P, OFF_P, OFF_M}, '{OFF_P, OFF_M, OFF_M}, '{OFF_P, OFF_Z, OFF_P},
    '{OFF_Z, OFF_P, OFF_P}, '{OFF_P, OFF_P, OFF_P}, '{OFF_P, OFF_M, OFF_P},
    '{OFF_Z, OFF_Z, OFF_P}
  };

endpackage

>>> rtl/core/half_shell_neighbor_cell_ids.sv
// Half-shell neighbor cell ids for a periodic 3-D cell list. Each input transfer names one
// cell by its grid coordinates and yields 13 result transfers, one per half-shell stencil
// slot, carrying the cell's linear id, the slot number and the wrapped neighbor's linear id
// (x + y*count_x + z*count_x*count_y, kept to 18 bits). A coordinate not below its count
// sets the flag in out_tuser and zeroes both ids. The slot sequencer issues one slot per
// cycle, unless a stalled output holds it, into a three-stage datapath (wrap, multiply,
// sum), and the next input is taken in the cycle its last slot issues. Counts are
// saturated to MAX_CELLS_PER_AXIS and may only be written while no item is in flight.
module half_shell_neighbor_cell_ids #(
  parameter int MAX_CELLS_PER_AXIS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [hsn_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,   // cell_x, cell_y, cell_z, zero fill
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [39:0]               out_tdata,  // home_id, slot, neighbor_id
  output logic                      out_tuser,  // bad_coord
  output logic                      out_tlast
);
  import hsn_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CLAMP = CNT_W'(MAX_CELLS_PER_AXIS);

  function automatic logic [CNT_W-1:0] wrap_step(input logic [COORD_W-1:0] c,
                                                 input off_t off,
                                                 input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] up;
    up = {1'b0, c} + CNT_W'(1);
    unique case (off)
      OFF_P:   wrap_step = (up >= n) ? '0 : up;
      OFF_M:   wrap_step = (c == '0) ? n - CNT_W'(1) : {1'b0, c} - CNT_W'(1);
      default: wrap_step = {1'b0, c};
    endcase
  endfunction

  // Configuration registers.
  logic [CNT_W-1:0] count_x_r, count_y_r, count_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_x_r <= CNT_W'(1);
      count_y_r <= CNT_W'(1);
      count_z_r <= CNT_W'(1);
    end else if (cfg_we) begin
      if (cfg_addr == REG_COUNT_X) count_x_r <= cfg_wdata;
      if (cfg_addr == REG_COUNT_Y) count_y_r <= cfg_wdata;
      if (cfg_addr == REG_COUNT_Z) count_z_r <= cfg_wdata;
    end
  end

  logic [CNT_W-1:0] nx, ny, nz;
  assign nx = (32'(count_x_r) > MAX_CELLS_PER_AXIS) ? MAX_CLAMP : count_x_r;
  assign ny = (32'(count_y_r) > MAX_CELLS_PER_AXIS) ? MAX_CLAMP : count_y_r;
  assign nz = (32'(count_z_r) > MAX_CELLS_PER_AXIS) ? MAX_CLAMP : count_z_r;

  // Ready chain through the datapath stages.
  logic s1_v_r, s2_v_r, s3_v_r;
  logic rdy1, rdy2, rdy3;
  assign rdy3 = !s3_v_r || out_tready;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;

  // Item register and slot sequencer.
  logic                item_v_r;
  logic [COORD_W-1:0]  x_r, y_r, z_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                issue, in_acc;

  assign issue     = item_v_r && rdy1;
  assign in_tready = !item_v_r || (issue && slot_r == LAST_SLOT);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      slot_r   <= '0;
    end else begin
      if (issue) begin
        slot_r <= slot_r + SLOT_W'(1);
        if (slot_r == LAST_SLOT) item_v_r <= 1'b0;
      end
      if (in_acc) begin
        item_v_r <= 1'b1;
        slot_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_tdata[5:0];
      y_r <= in_tdata[11:6];
      z_r <= in_tdata[17:12];
    end
  end

  // Stage 1: periodic wrap, range check, nx*ny.
  logic [COORD_W-1:0]   s1_x_r, s1_y_r, s1_z_r;
  logic [CNT_W-1:0]     s1_ax_r, s1_ay_r, s1_az_r, s1_nx_r;
  logic [2*CNT_W-1:0]   s1_nxny_r;
  logic                 s1_bad_r, s1_last_r;
  logic [SLOT_W-1:0]    s1_slot_r;
  stencil_t             st;

  assign st = STENCIL[slot_r];

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (rdy1) s1_v_r <= issue;
  end

  always_ff @(posedge clk) begin
    if (rdy1 && issue) begin
      s1_x_r    <= x_r;
      s1_y_r    <= y_r;
      s1_z_r    <= z_r;
      s1_ax_r   <= wrap_step(x_r, st.dx, nx);
      s1_ay_r   <= wrap_step(y_r, st.dy, ny);
      s1_az_r   <= wrap_step(z_r, st.dz, nz);
      s1_nx_r   <= nx;
      s1_nxny_r <= nx * ny;
      s1_bad_r  <= !({1'b0, x_r} < nx && {1'b0, y_r} < ny && {1'b0, z_r} < nz);
      s1_slot_r <= slot_r;
      s1_last_r <= (slot_r == LAST_SLOT);
    end
  end

  // Stage 2: the y and z products for home and neighbor.
  logic [COORD_W-1:0]          s2_x_r;
  logic [CNT_W-1:0]            s2_ax_r;
  logic [COORD_W+CNT_W-1:0]    s2_hy_r;
  logic [COORD_W+2*CNT_W-1:0]  s2_hz_r;
  logic [2*CNT_W-1:0]          s2_ny_r;
  logic [3*CNT_W-1:0]          s2_nz_r;
  logic                        s2_bad_r, s2_last_r;
  logic [SLOT_W-1:0]           s2_slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (rdy2) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      s2_x_r    <= s1_x_r;
      s2_ax_r   <= s1_ax_r;
      s2_hy_r   <= s1_y_r * s1_nx_r;
      s2_hz_r   <= s1_z_r * s1_nxny_r;
      s2_ny_r   <= s1_ay_r * s1_nx_r;
      s2_nz_r   <= s1_az_r * s1_nxny_r;
      s2_bad_r  <= s1_bad_r;
      s2_slot_r <= s1_slot_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Stage 3: sums into the output register.
  logic [3*CNT_W+1:0] home_sum, nb_sum;
  logic [ID_W-1:0]    s3_home_r, s3_nb_r;
  logic               s3_bad_r, s3_last_r;
  logic [SLOT_W-1:0]  s3_slot_r;

  assign home_sum = (3*CNT_W+2)'(s2_x_r) + (3*CNT_W+2)'(s2_hy_r) + (3*CNT_W+2)'(s2_hz_r);
  assign nb_sum   = (3*CNT_W+2)'(s2_ax_r) + (3*CNT_W+2)'(s2_ny_r) + (3*CNT_W+2)'(s2_nz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (rdy3) s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_home_r <= s2_bad_r ? '0 : home_sum[ID_W-1:0];
      s3_nb_r   <= s2_bad_r ? '0 : nb_sum[ID_W-1:0];
      s3_bad_r  <= s2_bad_r;
      s3_slot_r <= s2_slot_r;
      s3_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = s3_v_r;
  assign out_tdata  = {s3_nb_r, s3_slot_r, s3_home_r};
  assign out_tuser  = s3_bad_r;
  assign out_tlast  = s3_last_r;

endmodule

>>> rtl/core/hsn_checker.sv
`include "half_shell_neighbor_cell_ids_assert.svh"

module hsn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);
  import hsn_pkg::*;

  logic [SLOT_W-1:0] slot;
  assign slot = out_tdata[21:18];

  // A stalled result must hold until it is taken.
  `HSN_ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed")

  // The last flag marks exactly the final stencil slot.
  `HSN_ASSERT_RST(a_last_slot, clk, rst_n, out_tvalid |-> (out_tlast == (slot == LAST_SLOT)) && (slot <= LAST_SLOT), "slot and last disagree")

  // A flagged cell gives zero ids.
  `HSN_ASSERT_RST(a_bad_zero, clk, rst_n, out_tvalid && out_tuser |-> out_tdata[17:0] == '0 && out_tdata[39:22] == '0, "flagged result has nonzero id")

  // Nothing can be in the pipeline right after reset.
  `HSN_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind half_shell_neighbor_cell_ids hsn_checker u_hsn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
